// ===== rtl/zlbw_pkg.sv =====
// ----------------------------------------------------------------------------
// zlbw_pkg
// Shared widths, packing constants and register indexes for the bilinear
// zoom-lerp weights block.
// ----------------------------------------------------------------------------
package zlbw_pkg;

  // Coordinate format: signed, with a fixed number of fraction bits.
  localparam int COORD_W   = 18;
  localparam int FRAC_BITS = 4;
  localparam int PIXEL_W   = COORD_W - FRAC_BITS;
  localparam int LERP_W    = 16;
  localparam int WEIGHT_W  = 8;

  // Difference, product and weight term widths.
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIFF_W + LERP_W + 1;
  localparam int SHIFT_W   = PROD_W - LERP_W;
  localparam int TERM_W    = FRAC_BITS + 1;
  localparam int WPROD_W   = 2 * TERM_W;

  // Stream packing.
  localparam int IN_TDATA_W   = 4 * COORD_W;
  localparam int OUT_FIELDS_W = 2 * COORD_W + 1 + 2 * PIXEL_W + 4 * WEIGHT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LERP_FACTOR = 2'd0,
    REG_MAX_COORD_X = 2'd1,
    REG_MAX_COORD_Y = 2'd2
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== rtl/zoom_lerp_bilinear_weights_top.sv =====
// Each accepted request passes the difference, product and sum stages of the
// axis pipelines, then the output register, before it shows on out_tvalid.
// One request per cycle; the pipeline advances as a whole whenever the output
// register is empty or being drained; the lerp multiplier has its own stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets
// lerp_factor to 0 and both clip bounds to 65535.
// ----------------------------------------------------------------------------
// zoom_lerp_bilinear_weights_top
// Blends source and destination coordinates, flags clipping and derives the
// integer screen point and the four bilinear weights.
// ----------------------------------------------------------------------------
module zoom_lerp_bilinear_weights_top
  import zlbw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // source_x, source_y, target_x, target_y (18 bits each)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // blended_x, blended_y, clipped, pixel_x, pixel_y,
  // weight_a, weight_b, weight_c, weight_d, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [TERM_W-1:0] FULL_TERM = TERM_W'(1) << FRAC_BITS;

  logic [LERP_W-1:0]     lerp_factor_r;
  logic [CFG_DATA_W-1:0] max_coord_x_r;
  logic [CFG_DATA_W-1:0] max_coord_y_r;
  logic [2:0]            valid_r;
  logic                  out_valid_r;
  logic                  en;

  coord_t bx, by;
  coord_t out_bx_r, out_by_r;
  logic   out_clip_r;
  logic signed [PIXEL_W-1:0] out_px_r, out_py_r;
  logic [WEIGHT_W-1:0] out_wa_r, out_wb_r, out_wc_r, out_wd_r;

  logic                 clip_nxt;
  logic [FRAC_BITS-1:0] h, v;
  logic [TERM_W-1:0]    hi, vi, hc, vc;
  logic [WPROD_W-1:0]   pa, pb, pc, pd;
  logic [WEIGHT_W-1:0]  wa_nxt, wb_nxt, wc_nxt, wd_nxt;

  // The whole pipeline moves when the output register can take a result.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lerp_factor_r <= '0;
      max_coord_x_r <= '1;
      max_coord_y_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LERP_FACTOR: lerp_factor_r <= cfg_wdata[LERP_W-1:0];
        REG_MAX_COORD_X: max_coord_x_r <= cfg_wdata;
        REG_MAX_COORD_Y: max_coord_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Blend pipelines, one for each axis.
  zlbw_axis u_axis_x (
    .clk         (clk),
    .en          (en),
    .src         (coord_t'(in_tdata[COORD_W-1:0])),
    .dst         (coord_t'(in_tdata[3*COORD_W-1:2*COORD_W])),
    .lerp_factor (lerp_factor_r),
    .blend       (bx)
  );

  zlbw_axis u_axis_y (
    .clk         (clk),
    .en          (en),
    .src         (coord_t'(in_tdata[2*COORD_W-1:COORD_W])),
    .dst         (coord_t'(in_tdata[4*COORD_W-1:3*COORD_W])),
    .lerp_factor (lerp_factor_r),
    .blend       (by)
  );

  // Clip test: negative, or at or beyond the bound on either axis.
  assign clip_nxt = bx[COORD_W-1] || by[COORD_W-1] ||
                    ({1'b0, bx[COORD_W-2:0]} >= (COORD_W)'(max_coord_x_r)) ||
                    ({1'b0, by[COORD_W-2:0]} >= (COORD_W)'(max_coord_y_r));

  // Bilinear weights from the fraction bits; a zero fraction gives 255, 0, 0, 0.
  assign h  = bx[FRAC_BITS-1:0];
  assign v  = by[FRAC_BITS-1:0];
  assign hi = TERM_W'(h);
  assign vi = TERM_W'(v);
  assign hc = FULL_TERM - hi;
  assign vc = FULL_TERM - vi;
  assign pa = WPROD_W'(hc) * WPROD_W'(vc);
  assign pb = WPROD_W'(hi) * WPROD_W'(vc);
  assign pc = WPROD_W'(hc) * WPROD_W'(vi);
  assign pd = WPROD_W'(hi) * WPROD_W'(vi);

  always_comb begin
    wa_nxt = (pa != '0) ? WEIGHT_W'(pa - WPROD_W'(1)) : '0;
    wb_nxt = (pb != '0) ? WEIGHT_W'(pb - WPROD_W'(1)) : '0;
    wc_nxt = (pc != '0) ? WEIGHT_W'(pc - WPROD_W'(1)) : '0;
    wd_nxt = (pd != '0) ? WEIGHT_W'(pd - WPROD_W'(1)) : '0;
  end

  // Valid bits travelling beside the axis stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      valid_r     <= {valid_r[1:0], in_tvalid};
      out_valid_r <= valid_r[2];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_bx_r   <= bx;
      out_by_r   <= by;
      out_clip_r <= clip_nxt;
      out_px_r   <= bx[COORD_W-1:FRAC_BITS];
      out_py_r   <= by[COORD_W-1:FRAC_BITS];
      out_wa_r   <= wa_nxt;
      out_wb_r   <= wb_nxt;
      out_wc_r   <= wc_nxt;
      out_wd_r   <= wd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_wd_r, out_wc_r, out_wb_r, out_wa_r,
                       out_py_r, out_px_r, out_clip_r, out_by_r, out_bx_r};

`ifndef SYNTHESIS
  // A held result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("request accepted while a result is held");

  // A result that is not clipped lies in the positive quadrant.
  a_clip_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_clip_r |-> !out_bx_r[COORD_W-1] && !out_by_r[COORD_W-1])
    else $error("negative point not flagged as clipped");

  // A point on the grid puts all weight on the top-left sample.
  a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bx_r[FRAC_BITS-1:0] == '0 && out_by_r[FRAC_BITS-1:0] == '0
    |-> out_wa_r == '1 && out_wb_r == '0 && out_wc_r == '0 && out_wd_r == '0)
    else $error("zero fraction gave wrong weights");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && valid_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== rtl/zlbw_axis.sv =====
// ----------------------------------------------------------------------------
// zlbw_axis
// Three-stage blend of one axis: difference, wide product, then the source
// plus the product floored by the lerp shift.
// ----------------------------------------------------------------------------
module zlbw_axis
  import zlbw_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  coord_t            src,
  input  coord_t            dst,
  input  logic [LERP_W-1:0] lerp_factor,
  output coord_t            blend
);

  logic signed [DIFF_W-1:0]  diff_r;
  coord_t                    src1_r;
  logic signed [PROD_W-1:0]  prod_r;
  coord_t                    src2_r;
  coord_t                    blend_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SHIFT_W-1:0] sum_nxt;

  // The factor is unsigned, so it enters the product with a zero sign bit.
  assign prod_nxt = PROD_W'($signed({1'b0, lerp_factor}) * diff_r);

  // Arithmetic shift of the product floors it; the sum always fits.
  assign sum_nxt = SHIFT_W'($signed(src2_r)) + $signed(prod_r[PROD_W-1:LERP_W]);

  // Stage registers, advanced together by the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      diff_r  <= DIFF_W'($signed(dst)) - DIFF_W'($signed(src));
      src1_r  <= src;
      prod_r  <= prod_nxt;
      src2_r  <= src1_r;
      blend_r <= sum_nxt[COORD_W-1:0];
    end
  end

  assign blend = blend_r;

endmodule
